FILE: hw/rtl/arrw_pkg.sv
`default_nettype none

package arrw_pkg;

    localparam int unsigned CONTEXT_BASE_REG = 28;

    localparam logic [31:0] IMM_MASK    = 32'h1F80_0000;
    localparam logic [31:0] IMM_MATCH   = 32'h1100_0000;
    localparam logic [31:0] SHIFT_MASK  = 32'h1F20_0000;
    localparam logic [31:0] SHIFT_MATCH = 32'h0B00_0000;

    localparam logic [4:0] SCRATCH_A = 5'd16;
    localparam logic [4:0] SCRATCH_B = 5'd17;
    localparam logic [4:0] ZERO_REG  = 5'd31;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_EMIT   = 2'd1,
        KIND_STORE  = 2'd2,
        KIND_REJECT = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [4:0]  reg_num;
        logic [7:0]  ctx_offset;
        logic [31:0] emit_word;
    } micro_op_t;

    // Up to four micro-ops per instruction; last_idx marks the final one.
    typedef struct packed {
        micro_op_t [3:0] ops;
        logic [1:0]      last_idx;
    } op_seq_t;

    function automatic logic is_reserved(input logic [4:0] r);
        return (r == 5'd16) || (r == 5'd17) || (r == 5'd18) || (r == 5'd30) ||
               (r == 5'(CONTEXT_BASE_REG));
    endfunction

    function automatic logic [7:0] slot_offset(input logic [4:0] r);
        return {r, 3'b000};
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/arrw_decode.sv
`default_nettype none

module arrw_decode
    import arrw_pkg::*;
(
    input  wire logic [31:0] word,
    output op_seq_t          seq
);

    logic [4:0] dst;
    logic [4:0] left;
    logic [4:0] right;
    logic       dst_res;
    logic       lr;
    logic       rr;
    logic [4:0] nl;
    logic [4:0] nr;
    logic [4:0] nd;
    logic       no_scratch;
    logic [1:0] pos;

    assign dst     = word[4:0];
    assign left    = word[9:5];
    assign right   = word[20:16];
    assign dst_res = (dst != ZERO_REG) && is_reserved(dst);
    assign lr      = is_reserved(left);
    assign rr      = is_reserved(right);

    always_comb
    begin
        seq        = '0;
        pos        = '0;
        nl         = lr ? SCRATCH_A : left;
        nr         = rr ? SCRATCH_B : right;
        nd         = dst;
        no_scratch = 1'b0;

        if ((word & SHIFT_MASK) == SHIFT_MATCH)
        begin
            // Destination reuses a matching source scratch, else a free one.
            if (dst_res)
            begin
                if (dst == left)
                    nd = nl;
                else if (dst == right)
                    nd = nr;
                else if (!lr)
                    nd = SCRATCH_A;
                else if (!rr)
                    nd = SCRATCH_B;
                else
                    no_scratch = 1'b1;
            end

            if (no_scratch)
            begin
                seq.ops[0].kind = KIND_REJECT;
            end
            else
            begin
                if (lr)
                begin
                    seq.ops[pos] = '{KIND_LOAD, SCRATCH_A, slot_offset(left), 32'd0};
                    pos          = pos + 2'd1;
                end
                if (rr)
                begin
                    seq.ops[pos] = '{KIND_LOAD, SCRATCH_B, slot_offset(right), 32'd0};
                    pos          = pos + 2'd1;
                end
                seq.ops[pos] = '{KIND_EMIT, 5'd0, 8'd0,
                                 {word[31:21], nr, word[15:10], nl, nd}};
                if (dst_res)
                begin
                    pos          = pos + 2'd1;
                    seq.ops[pos] = '{KIND_STORE, nd, slot_offset(dst), 32'd0};
                end
                seq.last_idx = pos;
            end
        end
        else if ((word & IMM_MASK) == IMM_MATCH)
        begin
            if (lr)
            begin
                seq.ops[pos] = '{KIND_LOAD, SCRATCH_A, slot_offset(left), 32'd0};
                pos          = pos + 2'd1;
            end
            seq.ops[pos] = '{KIND_EMIT, 5'd0, 8'd0,
                             {word[31:10], nl, (dst_res ? SCRATCH_B : dst)}};
            if (dst_res)
            begin
                pos          = pos + 2'd1;
                seq.ops[pos] = '{KIND_STORE, SCRATCH_B, slot_offset(dst), 32'd0};
            end
            seq.last_idx = pos;
        end
        else
        begin
            seq.ops[0].kind = KIND_REJECT;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/add_register_remap_rewriter.sv
`default_nettype none

// A transaction is accepted into the input register and decoded combinationally; its first
// result is then loaded into the output register. One input yields one to four results
//   (reject: 1); the output register issues one micro-op a cycle unless stalled and sets the pace.
// A new input is taken in the cycle its predecessor's last result is loaded.
// Reset (rst_n low, asynchronous) clears both valid flags and the sequence index.

module add_register_remap_rewriter
    import arrw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] instr_word,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       op_kind,
    output logic [4:0]       reg_num,
    output logic [7:0]       ctx_offset,
    output logic [31:0]      emit_word,
    output logic             last
);

    logic        in_valid_reg;
    logic [31:0] word_reg;
    logic [1:0]  idx_reg;
    logic        out_valid_reg;
    micro_op_t   op_reg;
    logic        last_reg;

    op_seq_t     seq;
    logic        load_out;
    logic        seq_done;

    arrw_decode u_decode (
        .word (word_reg),
        .seq  (seq)
    );

    assign load_out = in_valid_reg && (!out_valid_reg || !out_stall);
    assign seq_done = load_out && (idx_reg == seq.last_idx);
    assign in_stall = in_valid_reg && !seq_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;

            if (seq_done)
                idx_reg <= '0;
            else if (load_out)
                idx_reg <= idx_reg + 2'd1;

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            word_reg <= instr_word;
        if (load_out)
        begin
            op_reg   <= seq.ops[idx_reg];
            last_reg <= seq_done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign op_kind    = op_reg.kind;
    assign reg_num    = op_reg.reg_num;
    assign ctx_offset = op_reg.ctx_offset;
    assign emit_word  = op_reg.emit_word;
    assign last       = last_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> (idx_reg <= seq.last_idx))
        else $error("sequence index past last micro-op");

    a_idx_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> (idx_reg == 2'd0))
        else $error("sequence index not reset between transactions");

    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (op_reg.kind == KIND_REJECT)) |-> last_reg)
        else $error("reject result not marked last");

    a_word_only_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (op_reg.kind != KIND_EMIT)) |-> (op_reg.emit_word == 32'd0))
        else $error("nonzero word on non-emit result");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none

module tb_top
    import arrw_pkg::*;
();

    typedef struct packed {
        op_kind_t    kind;
        logic [4:0]  regnum;
        logic [7:0]  offset;
        logic [31:0] word;
        logic        last_flag;
    } uop_t;

    typedef struct packed {
        logic [31:0] word;
        logic        has_lit;
        uop_t        lit;
    } dir_row_t;

    localparam uop_t REJECTED = '{KIND_REJECT, 5'd0, 8'd0, 32'd0, 1'b1};
    localparam uop_t NO_LIT   = '{KIND_LOAD, 5'd0, 8'd0, 32'd0, 1'b0};

    localparam int N_DIRECTED = 20;
    localparam int N_RANDOM   = 210;
    localparam int IDLE_PCT   = 7;

    // Rows with has_lit set carry an expectation readable at a glance; the rest go
    // through the predictor.
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{32'h0000_0000, 1'b1, REJECTED},
        '{32'hFFFF_FFFF, 1'b1, REJECTED},
        '{32'h9100_0422, 1'b1, '{KIND_EMIT, 5'd0, 8'd0, 32'h9100_0422, 1'b1}},
        '{32'h9100_039E, 1'b0, NO_LIT},
        '{32'h9100_021F, 1'b0, NO_LIT},
        '{32'h9100_03F1, 1'b0, NO_LIT},
        '{32'hF17F_FFFF, 1'b0, NO_LIT},
        '{32'h5100_0231, 1'b0, NO_LIT},
        '{32'h8B02_0020, 1'b0, NO_LIT},
        '{32'h8B11_0210, 1'b0, NO_LIT},
        '{32'h8B1E_025E, 1'b0, NO_LIT},
        '{32'h8B1C_0072, 1'b0, NO_LIT},
        '{32'h8B04_03D1, 1'b0, NO_LIT},
        '{32'h8B1C_021F, 1'b0, NO_LIT},
        '{32'hEBDF_FFFF, 1'b0, NO_LIT},
        '{32'h8B05_039C, 1'b0, NO_LIT},
        '{32'h0B11_0212, 1'b1, REJECTED},
        '{32'hCB1E_025C, 1'b1, REJECTED},
        '{32'hB140_039E, 1'b0, NO_LIT},
        '{32'h8B20_0000, 1'b1, REJECTED}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] instr_word;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  op_kind;
    logic [4:0]  reg_num;
    logic [7:0]  ctx_offset;
    logic [31:0] emit_word;
    logic        last;

    uop_t expected_uops[$];
    int   n_accepted;
    int   n_failures;
    int   hold_left;
    bit   hold_done;

    add_register_remap_rewriter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .instr_word (instr_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .op_kind    (op_kind),
        .reg_num    (reg_num),
        .ctx_offset (ctx_offset),
        .emit_word  (emit_word),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("status: fail");
        $finish;
    end

    function automatic bit banked_reg(input logic [4:0] r);
        return (r == 5'd16) || (r == 5'd17) || (r == 5'd18) || (r == 5'd30) ||
               (r == 5'(CONTEXT_BASE_REG));
    endfunction

    function automatic uop_t uop(input op_kind_t k, input logic [4:0] r,
                                 input logic [4:0] guest, input logic [31:0] w);
        uop_t u;
        u.kind      = k;
        u.regnum    = r;
        u.offset    = {guest, 3'b000};
        u.word      = w;
        u.last_flag = 1'b0;
        return u;
    endfunction

    // Push the micro-op sequence one instruction word turns into.
    function automatic void predict_rewrite(input logic [31:0] w);
        logic [4:0] rd, rn, rm, nd, nn, nm;
        bit         rd_b, rn_b, rm_b, no_scratch;
        uop_t       seq[$];
        rd         = w[4:0];
        rn         = w[9:5];
        rm         = w[20:16];
        rd_b       = (rd != ZERO_REG) && banked_reg(rd);
        rn_b       = banked_reg(rn);
        rm_b       = banked_reg(rm);
        no_scratch = 1'b0;
        if ((w & SHIFT_MASK) == SHIFT_MATCH)
        begin
            nn = rn_b ? SCRATCH_A : rn;
            nm = rm_b ? SCRATCH_B : rm;
            nd = rd;
            if (rd_b)
            begin
                if (rd == rn)
                    nd = nn;
                else if (rd == rm)
                    nd = nm;
                else if (!rn_b)
                    nd = SCRATCH_A;
                else if (!rm_b)
                    nd = SCRATCH_B;
                else
                    no_scratch = 1'b1;
            end
            if (no_scratch)
                seq.push_back(REJECTED);
            else
            begin
                if (rn_b)
                    seq.push_back(uop(KIND_LOAD, SCRATCH_A, rn, 32'd0));
                if (rm_b)
                    seq.push_back(uop(KIND_LOAD, SCRATCH_B, rm, 32'd0));
                seq.push_back(uop(KIND_EMIT, 5'd0, 5'd0, {w[31:21], nm, w[15:10], nn, nd}));
                if (rd_b)
                    seq.push_back(uop(KIND_STORE, nd, rd, 32'd0));
            end
        end
        else if ((w & IMM_MASK) == IMM_MATCH)
        begin
            nn = rn_b ? SCRATCH_A : rn;
            nd = rd_b ? SCRATCH_B : rd;
            if (rn_b)
                seq.push_back(uop(KIND_LOAD, SCRATCH_A, rn, 32'd0));
            seq.push_back(uop(KIND_EMIT, 5'd0, 5'd0, {w[31:10], nn, nd}));
            if (rd_b)
                seq.push_back(uop(KIND_STORE, SCRATCH_B, rd, 32'd0));
        end
        else
            seq.push_back(REJECTED);
        seq[seq.size() - 1].last_flag = 1'b1;
        foreach (seq[i])
            expected_uops.push_back(seq[i]);
    endfunction

    // Bias register fields toward the reserved set and the zero register.
    function automatic logic [4:0] pick_reg();
        int unsigned c;
        c = $urandom_range(9);
        case (c)
            0:       return 5'd16;
            1:       return 5'd17;
            2:       return 5'd18;
            3:       return 5'(CONTEXT_BASE_REG);
            4:       return 5'd30;
            5:       return ZERO_REG;
            default: return 5'($urandom_range(31));
        endcase
    endfunction

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        int unsigned sel;
        w   = $urandom;
        sel = $urandom_range(99);
        if (sel < 45)
            w = (w & ~IMM_MASK) | IMM_MATCH;
        else if (sel < 90)
            w = (w & ~SHIFT_MASK) | SHIFT_MATCH;
        if (sel < 90)
        begin
            w[4:0] = pick_reg();
            w[9:5] = pick_reg();
            if (sel >= 45)
                w[20:16] = pick_reg();
        end
        return w;
    endfunction

    function automatic bit quiet_window();
        return n_accepted >= 140 && n_accepted < 200;
    endfunction

    task automatic offer(input logic [31:0] w, input logic has_lit, input uop_t lit);
        while (!quiet_window() && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        instr_word <= w;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (has_lit)
            expected_uops.push_back(lit);
        else
            predict_rewrite(w);
        n_accepted++;
    endtask

    task automatic check_result();
        uop_t got, want;
        got = '{op_kind_t'(op_kind), reg_num, ctx_offset, emit_word, last};
        if (expected_uops.size() == 0)
        begin
            if (n_failures < 10)
                $display("unexpected transaction: kind %0d reg %0d off %0d word %h last %b",
                         got.kind, got.regnum, got.offset, got.word, got.last_flag);
            n_failures++;
        end
        else
        begin
            want = expected_uops.pop_front();
            if (got.kind !== want.kind || got.regnum !== want.regnum ||
                got.offset !== want.offset || got.word !== want.word ||
                got.last_flag !== want.last_flag)
            begin
                if (n_failures < 10)
                    $display({"mismatch: expected kind %0d reg %0d off %0d word %h last %b,",
                              " got kind %0d reg %0d off %0d word %h last %b"},
                             want.kind, want.regnum, want.offset, want.word, want.last_flag,
                             got.kind, got.regnum, got.offset, got.word, got.last_flag);
                n_failures++;
            end
        end
    endtask

    // Output side: random stalls, one long hold-off to back the block up.
    initial
    begin
        hold_left = 0;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                check_result();
            if (!hold_done && n_accepted >= 100)
            begin
                hold_left = 150;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (quiet_window())
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        n_accepted = 0;
        n_failures = 0;
        rst_n      = 1'b0;
        in_valid   <= 1'b0;
        instr_word <= 32'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++)
            offer(DIRECTED[i].word, DIRECTED[i].has_lit, DIRECTED[i].lit);
        for (int i = 0; i < N_RANDOM; i++)
            offer(random_word(), 1'b0, NO_LIT);
        in_valid <= 1'b0;
        while (expected_uops.size() != 0)
            @(posedge clk);
        // drain: catch any stray transaction after the last expected one
        repeat (8) @(posedge clk);
        if (n_failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
